### design/ktok_pkg.sv
// Shared types and constants for the keyword tokenizer.
// Holds token kind codes, byte codes, the keyword table and the result word type.
// No dependencies.
package ktok_pkg;

  localparam int KW_NUM   = 17;
  localparam int KW_CHARS = 9;

  localparam logic [4:0] K_NUMBER   = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_KEYWORD0 = 5'd2;
  localparam logic [4:0] K_PLUS     = 5'd19;
  localparam logic [4:0] K_MINUS    = 5'd20;
  localparam logic [4:0] K_ASSIGN   = 5'd21;
  localparam logic [4:0] K_LESS     = 5'd22;
  localparam logic [4:0] K_END      = 5'd23;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Keyword text is right-justified in each entry, first character highest.
  localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_NUM] = '{
    "ENTIER", "REEL", "CHAINE", "BOOLEEN", "SI", "ALORS", "SINON", "FIN",
    "POUR", "DE", "A", "FAIRE", "FONCTION", "RETOURNER", "AFFICHER",
    "VRAI", "FAUX"
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd6, 4'd4, 4'd6, 4'd7, 4'd2, 4'd5, 4'd5, 4'd3, 4'd4, 4'd2, 4'd1,
    4'd5, 4'd8, 4'd9, 4'd8, 4'd4, 4'd4
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } cand_t;

  // Returns character j of keyword k.
  function automatic logic [7:0] kw_char(int k, int j);
    logic [KW_CHARS*8-1:0] t;
    t = KW_TEXT[k] << (8 * (KW_CHARS - int'(KW_LEN[k])));
    return t[8*(KW_CHARS-1-j) +: 8];
  endfunction

endpackage

### design/keyword_tokenizer_top.sv
// Keyword tokenizer: one source byte per word in, tokens out as kind, start and length.
// An accepted byte is registered at the input, and its result words in the result buffer.
// Throughput is one input word per cycle while each byte yields at most one token and
// out_ready_i stays high; a byte that yields two or three tokens holds the input until
// the three-entry result buffer, draining one word per cycle, is down to its last word.
// Reset (rst_ni low, asynchronous) returns the scanner to idle at offset zero.
// Depends on ktok_pkg.
module keyword_tokenizer_top import ktok_pkg::*; #(
  parameter int MaxKeywordLen = 9,
  parameter int PositionBits  = 32,
  parameter int LengthBits    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  kind_o,
  output logic [31:0] start_res_o,
  output logic [15:0] length_o,
  output logic        run_last_o
);

  localparam int KwIdxBits = $clog2(MaxKeywordLen);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_LESS
  } mode_e;

  typedef logic [MaxKeywordLen-1:0][7:0] kwbuf_t;

  logic                    in_valid_q;
  logic [7:0]              ch_q;
  logic                    last_q;
  mode_e                   mode_q, mode_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] start_q, start_d;
  logic [LengthBits-1:0]   len_q, len_d;
  kwbuf_t                  kwbuf_q, kwbuf_d;
  logic                    ended_q, ended_d;
  res_t                    res_q [3];
  logic [1:0]              cnt_q;

  logic                    pop, free, proc, in_acc;
  logic [LengthBits-1:0]   len_inc;
  logic                    is_dig, is_alp;
  cand_t                   cand [4];
  res_t                    pk [4];
  logic [1:0]              n_res;

  function automatic logic [4:0] classify(logic [LengthBits-1:0] n, kwbuf_t b);
    logic [4:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < KW_NUM; i++) begin
      hit = (n == LengthBits'(KW_LEN[i]));
      for (int j = 0; j < KW_CHARS; j++) begin
        if (j < int'(KW_LEN[i])) begin
          hit = hit & (b[j] == kw_char(i, j));
        end
      end
      if (hit) begin
        k = 5'(int'(K_KEYWORD0) + i);
      end
    end
    return k;
  endfunction

  function automatic cand_t flush_tok(mode_e m, logic [PositionBits-1:0] s,
                                      logic [LengthBits-1:0] n, kwbuf_t b);
    cand_t r;
    r.valid        = (m != MODE_IDLE);
    r.res.start    = 32'(s);
    r.res.length   = 16'(n);
    r.res.run_last = 1'b0;
    case (m)
      MODE_NUMBER: r.res.kind = K_NUMBER;
      MODE_IDENT:  r.res.kind = classify(n, b);
      MODE_LESS: begin
        r.res.kind   = K_LESS;
        r.res.length = 16'd1;
      end
      default:     r.res.kind = K_NUMBER;
    endcase
    return r;
  endfunction

  function automatic cand_t mk_tok(logic [4:0] k, logic [PositionBits-1:0] s,
                                   logic [15:0] n);
    cand_t r;
    r.valid        = 1'b1;
    r.res.kind     = k;
    r.res.start    = 32'(s);
    r.res.length   = n;
    r.res.run_last = 1'b0;
    return r;
  endfunction

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign free        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign proc        = in_valid_q && free;
  assign in_ready_o  = !in_valid_q || proc;
  assign in_acc      = in_valid_i && in_ready_o;

  assign kind_o      = res_q[0].kind;
  assign start_res_o = res_q[0].start;
  assign length_o    = res_q[0].length;
  assign run_last_o  = res_q[0].run_last;

  assign len_inc = (len_q == '1) ? len_q : len_q + LengthBits'(1);
  assign is_dig  = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign is_alp  = ((ch_q >= CH_UP_A) && (ch_q <= CH_UP_Z)) ||
                   ((ch_q >= CH_LO_A) && (ch_q <= CH_LO_Z));

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    kwbuf_d = kwbuf_q;
    ended_d = ended_q;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    if (!ended_q) begin
      if (ch_q == CH_NUL) begin
        cand[0] = flush_tok(mode_q, start_q, len_q, kwbuf_q);
        cand[3] = mk_tok(K_END, pos_q, 16'd0);
        mode_d  = MODE_IDLE;
        ended_d = 1'b1;
      end else begin
        if ((mode_q == MODE_LESS) && (ch_q == CH_MINUS)) begin
          cand[1] = mk_tok(K_ASSIGN, start_q, 16'd2);
          mode_d  = MODE_IDLE;
        end else if ((mode_q == MODE_NUMBER) && is_dig) begin
          len_d = len_inc;
        end else if ((mode_q == MODE_IDENT) && (is_dig || is_alp)) begin
          if (len_q < LengthBits'(MaxKeywordLen)) begin
            kwbuf_d[len_q[KwIdxBits-1:0]] = ch_q;
          end
          len_d = len_inc;
        end else begin
          cand[0] = flush_tok(mode_q, start_q, len_q, kwbuf_q);
          mode_d  = MODE_IDLE;
          if (is_dig) begin
            mode_d  = MODE_NUMBER;
            start_d = pos_q;
            len_d   = LengthBits'(1);
          end else if (is_alp) begin
            mode_d     = MODE_IDENT;
            start_d    = pos_q;
            len_d      = LengthBits'(1);
            kwbuf_d[0] = ch_q;
          end else if (ch_q == CH_PLUS) begin
            cand[1] = mk_tok(K_PLUS, pos_q, 16'd1);
          end else if (ch_q == CH_MINUS) begin
            cand[1] = mk_tok(K_MINUS, pos_q, 16'd1);
          end else if (ch_q == CH_LESS) begin
            mode_d  = MODE_LESS;
            start_d = pos_q;
            len_d   = LengthBits'(1);
          end
        end
        pos_d = pos_q + PositionBits'(1);
        if (last_q) begin
          cand[2] = flush_tok(mode_d, start_d, len_d, kwbuf_d);
          cand[3] = mk_tok(K_END, pos_d, 16'd0);
          mode_d  = MODE_IDLE;
          ended_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    n_res = 2'd0;
    for (int i = 0; i < 4; i++) begin
      pk[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand[i].valid) begin
        pk[n_res] = cand[i].res;
        n_res     = n_res + 2'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      pk[i].run_last = (2'(i) == (n_res - 2'd1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= 2'd0;
      mode_q     <= MODE_IDLE;
      pos_q      <= '0;
      start_q    <= '0;
      len_q      <= '0;
      ended_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        cnt_q   <= n_res;
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        len_q   <= len_d;
        ended_q <= ended_d;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    if (proc) begin
      kwbuf_q <= kwbuf_d;
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= pk[i];
      end
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

`ifndef SYNTHESIS
  a_ended_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> (mode_q == MODE_IDLE))
    else $error("scanner not idle after end of source");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> res_q[0].run_last)
    else $error("final buffered word lacks run_last");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_ready_o) |-> (cnt_q != 2'd0))
    else $error("input stalled with empty result buffer");

  a_end_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == K_END)) |-> ended_q)
    else $error("end token offered before source ended");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (len_q != '0))
    else $error("pending token with zero length");
`endif

endmodule

### tb/sv/tb_keyword_tokenizer_top.sv
// Self-checking testbench for keyword_tokenizer_top: a queue-fed driver streams one
// source, an in-bench tokenizer predicts every token word, and a monitor checks them.
// Depends on ktok_pkg and keyword_tokenizer_top.
module tb_keyword_tokenizer_top;
  import ktok_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam int         LONG_RUN = 20;
  localparam int         HOLD_LEN = 300;
  localparam int         WD_LIMIT = 5000;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_NAME, SCAN_LESS} scan_e;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } src_byte_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  ch_i        = '0;
  logic        last_i      = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [4:0]  kind_o;
  logic [31:0] start_res_o;
  logic [15:0] length_o;
  logic        run_last_o;

  string kw_names [KW_NUM] = '{
    "ENTIER", "REEL", "CHAINE", "BOOLEEN", "SI", "ALORS", "SINON", "FIN",
    "POUR", "DE", "A", "FAIRE", "FONCTION", "RETOURNER", "AFFICHER",
    "VRAI", "FAUX"
  };

  src_byte_t src_q [$];
  res_t      token_exp_q [$];
  res_t      step_q [$];
  bit        drain_mark = 1'b0;

  scan_e       scan = SCAN_IDLE;
  logic [31:0] byte_pos = '0;
  logic [31:0] tok_start = '0;
  logic [15:0] tok_len = '0;
  logic [7:0]  name_buf [KW_CHARS];
  bit          src_done = 1'b0;

  int in_count = 0;
  int out_count = 0;
  int errors = 0;
  int rnd_base = 0;
  int hold_at = 0;
  int quiet_from = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  keyword_tokenizer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .start_res_o (start_res_o),
    .length_o    (length_o),
    .run_last_o  (run_last_o)
  );

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r = $urandom_range(0, 51);
    if (r < 26) return 8'(CH_UP_A + r);
    return 8'(CH_LO_A + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 5) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_space();
    int r = $urandom_range(0, 5);
    if (r == 5) return CH_SPACE;
    return 8'(CH_TAB + r);
  endfunction

  function automatic bit idle_ok();
    return in_count < quiet_from && (in_count % 128) < 96;
  endfunction

  function automatic logic [4:0] name_kind();
    bit hit;
    if (tok_len > KW_CHARS) return K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      hit = kw_names[k].len() == int'(tok_len);
      for (int j = 0; hit && j < kw_names[k].len(); j++) begin
        if (name_buf[j] != kw_names[k][j]) hit = 1'b0;
      end
      if (hit) return 5'(K_KEYWORD0 + k);
    end
    return K_IDENT;
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic l);
    src_byte_t b;
    b.ch = c;
    b.last = l;
    b.drain = drain_mark;
    drain_mark = 1'b0;
    src_q = {src_q, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  task automatic push_token(input logic [4:0] k, input logic [31:0] s, input logic [15:0] l);
    res_t r;
    r.kind = k;
    r.start = s;
    r.length = l;
    r.run_last = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic flush_pending();
    case (scan)
      SCAN_NUMBER: push_token(K_NUMBER, tok_start, tok_len);
      SCAN_NAME:   push_token(name_kind(), tok_start, tok_len);
      SCAN_LESS:   push_token(K_LESS, tok_start, 16'd1);
      default: ;
    endcase
    scan = SCAN_IDLE;
  endtask

  task automatic scan_byte(input logic [7:0] c);
    bit taken = 1'b0;
    case (scan)
      SCAN_LESS: begin
        if (c == CH_MINUS) begin
          scan = SCAN_IDLE;
          push_token(K_ASSIGN, tok_start, 16'd2);
          taken = 1'b1;
        end else begin
          flush_pending();
        end
      end
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          if (tok_len != 16'hFFFF) tok_len++;
          taken = 1'b1;
        end else begin
          flush_pending();
        end
      end
      SCAN_NAME: begin
        if (is_digit(c) || is_letter(c)) begin
          if (tok_len < KW_CHARS) name_buf[tok_len] = c;
          if (tok_len != 16'hFFFF) tok_len++;
          taken = 1'b1;
        end else begin
          flush_pending();
        end
      end
      default: ;
    endcase
    if (!taken) begin
      if (is_digit(c)) begin
        scan = SCAN_NUMBER;
        tok_start = byte_pos;
        tok_len = 16'd1;
      end else if (is_letter(c)) begin
        scan = SCAN_NAME;
        tok_start = byte_pos;
        tok_len = 16'd1;
        name_buf[0] = c;
      end else if (c == CH_PLUS) begin
        push_token(K_PLUS, byte_pos, 16'd1);
      end else if (c == CH_MINUS) begin
        push_token(K_MINUS, byte_pos, 16'd1);
      end else if (c == CH_LESS) begin
        scan = SCAN_LESS;
        tok_start = byte_pos;
        tok_len = 16'd1;
      end
    end
  endtask

  task automatic tokenize(input logic [7:0] c, input logic l);
    res_t r;
    if (src_done) return;
    step_q.delete();
    if (c == CH_NUL) begin
      flush_pending();
      push_token(K_END, byte_pos, 16'd0);
      src_done = 1'b1;
    end else begin
      scan_byte(c);
      byte_pos++;
      if (l) begin
        flush_pending();
        push_token(K_END, byte_pos, 16'd0);
        src_done = 1'b1;
      end
    end
    if (step_q.size() != 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      step_q = {step_q, r};
    end
    token_exp_q = {token_exp_q, step_q};
    step_q.delete();
  endtask

  task automatic check_token();
    res_t want;
    out_count++;
    if (token_exp_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected token: kind %0d start %0d len %0d last %0b",
                 kind_o, start_res_o, length_o, run_last_o);
      end
    end else begin
      want = token_exp_q.pop_front();
      if (want.kind !== kind_o || want.start !== start_res_o ||
          want.length !== length_o || want.run_last !== run_last_o) begin
        errors++;
        if (errors <= 10) begin
          $display("token %0d: expected kind %0d start %0d len %0d last %0b", out_count,
                   want.kind, want.start, want.length, want.run_last);
          $display("token %0d: got      kind %0d start %0d len %0d last %0b", out_count,
                   kind_o, start_res_o, length_o, run_last_o);
        end
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    src_byte_t it;
    bit        take;
    bit        nv;
    if (rst_ni) begin
      take = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        tokenize(ch_i, last_i);
        in_count++;
        take = 1'b1;
      end
      if (take) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (src_q.size() == 0) begin
          nv = 1'b0;
        end else if (src_q[0].drain && token_exp_q.size() != 0) begin
          nv = 1'b0;
        end else if (idle_ok() && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 4);
        end else begin
          it = src_q.pop_front();
          ch_i <= it.ch;
          last_i <= it.last;
          nv = 1'b1;
        end
        in_valid_i <= nv;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_token();
      if (!hold_done && in_count >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_ok() && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WD_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  sel;
    int  n;
    int  k;
    bit  drain_set;
    drain_set = 1'b0;

    add_text("FAIRE A1 9Z<-7+8-q<5<<-+ ");
    for (int i = 0; i < 5; i++) add_byte(8'(CH_TAB + i), 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("RETOURNER RETOURNERX ");
    for (int i = 0; i < LONG_RUN; i++) add_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    add_byte(CH_SPACE, 1'b0);
    add_byte(rand_letter(), 1'b0);
    for (int i = 1; i < LONG_RUN; i++) add_byte(rand_word_char(), 1'b0);
    add_byte(CH_SPACE, 1'b0);

    rnd_base = src_q.size();
    hold_at = rnd_base + 100;
    while (src_q.size() - rnd_base < 300) begin
      if (!drain_set && src_q.size() - rnd_base >= 150) begin
        drain_mark = 1'b1;
        drain_set = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        k = $urandom_range(0, KW_NUM - 1);
        add_text(kw_names[k]);
        if ($urandom_range(0, 3) == 0) add_byte(rand_word_char(), 1'b0);
      end else if (sel < 40) begin
        n = $urandom_range(1, 12);
        add_byte(rand_letter(), 1'b0);
        for (int i = 1; i < n; i++) add_byte(rand_word_char(), 1'b0);
      end else if (sel < 55) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      end else if (sel < 60) begin
        add_byte(CH_PLUS, 1'b0);
      end else if (sel < 65) begin
        add_byte(CH_MINUS, 1'b0);
      end else if (sel < 72) begin
        add_byte(CH_LESS, 1'b0);
      end else if (sel < 80) begin
        add_byte(CH_LESS, 1'b0);
        add_byte(CH_MINUS, 1'b0);
      end else if (sel < 90) begin
        add_byte(rand_space(), 1'b0);
      end else begin
        add_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      if ($urandom_range(0, 1) == 0) add_byte(rand_space(), 1'b0);
    end

    add_text("zq");
    if ($urandom_range(0, 1) == 0) add_byte(CH_PLUS, 1'b1);
    else add_byte(CH_NUL, 1'b1);
    for (int i = 0; i < 4; i++) begin
      add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    quiet_from = src_q.size() - 60;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (src_q.size() != 0 || in_valid_i || token_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    errors += token_exp_q.size();

    $display("Checked %0d tokens from %0d source bytes, including long number and name runs,",
             out_count, in_count);
    $display("keywords, operators, skipped bytes, a long output hold-off and a drain pause.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
